// ===== hdl/cdf_pkg.sv =====
// Shared types and constants for the checked frame to CAN deframer.
`default_nettype none
package cdf_pkg;

  localparam int ByteW  = 8;
  localparam int IdentW = 17;
  localparam int LenW   = 4;
  localparam int NumPay = 8;

  localparam logic [ByteW-1:0] LenMin  = 8'd4;
  localparam logic [ByteW-1:0] LenMax  = 8'd12;
  localparam logic [ByteW-1:0] LenOne  = 8'd1;
  localparam logic [LenW-1:0]  HdrLen  = 4'd4;
  localparam logic [ByteW-1:0] IdxHi   = 8'd1;
  localparam logic [ByteW-1:0] IdxLo   = 8'd2;
  localparam logic [2:0]       DataOfs = 3'd3;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_FRAME = 2'd1,
    PH_HALT  = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [IdentW-1:0]                can_ident;
    logic [LenW-1:0]                  data_len;
    logic [NumPay-1:0][ByteW-1:0]     payload;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/cdf_parser.sv =====
// Frame parser: phase, length, index, check and collected bytes; one byte per step.
`default_nettype none
module cdf_parser (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    step,
  input  wire logic [7:0]              rx_byte,
  input  wire logic                    chunk_end,
  output logic                         hit,
  output cdf_pkg::result_t             result
);

  cdf_pkg::phase_t phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] ident_hi, ident_lo;
  logic [cdf_pkg::NumPay-1:0][7:0] data_store;
  logic       hi_we, lo_we, data_we;
  logic [8:0] idx_inc;
  logic [2:0] data_addr;
  logic [3:0] dlen;

  assign idx_inc   = {1'b0, byte_index} + 9'd1;
  assign data_addr = byte_index[2:0] - cdf_pkg::DataOfs;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_index_next   = byte_index;
    running_xor_next  = running_xor;
    hit     = 1'b0;
    hi_we   = 1'b0;
    lo_we   = 1'b0;
    data_we = 1'b0;
    case (phase)
      cdf_pkg::PH_WAIT: begin
        if (rx_byte == 8'd0) begin
          phase_next = cdf_pkg::PH_HALT;
        end else if (rx_byte < cdf_pkg::LenMin || rx_byte > cdf_pkg::LenMax) begin
          frame_length_next = rx_byte;
          byte_index_next   = 8'd1;
          phase_next = (rx_byte == cdf_pkg::LenOne) ? cdf_pkg::PH_WAIT : cdf_pkg::PH_SKIP;
        end else begin
          frame_length_next = rx_byte;
          byte_index_next   = 8'd1;
          running_xor_next  = rx_byte;
          phase_next        = cdf_pkg::PH_FRAME;
        end
      end
      cdf_pkg::PH_FRAME: begin
        if (idx_inc >= {1'b0, frame_length}) begin
          // check byte
          hit              = (rx_byte == running_xor);
          phase_next       = cdf_pkg::PH_WAIT;
          byte_index_next  = 8'd0;
          running_xor_next = 8'd0;
        end else begin
          if (byte_index == cdf_pkg::IdxHi) begin
            hi_we = 1'b1;
          end else if (byte_index == cdf_pkg::IdxLo) begin
            lo_we = 1'b1;
          end else begin
            data_we = 1'b1;
          end
          running_xor_next = running_xor ^ rx_byte;
          byte_index_next  = idx_inc[7:0];
        end
      end
      cdf_pkg::PH_SKIP: begin
        byte_index_next = idx_inc[7:0];
        if (idx_inc >= {1'b0, frame_length}) begin
          phase_next      = cdf_pkg::PH_WAIT;
          byte_index_next = 8'd0;
        end
      end
      default: begin
      end
    endcase
    if (chunk_end) begin
      phase_next        = cdf_pkg::PH_WAIT;
      frame_length_next = 8'd0;
      byte_index_next   = 8'd0;
      running_xor_next  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cdf_pkg::PH_WAIT;
      frame_length <= 8'd0;
      byte_index   <= 8'd0;
      running_xor  <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_index   <= byte_index_next;
      running_xor  <= running_xor_next;
    end
  end

  // used bytes are rewritten before a frame's check, unused read zero, so no reset
  always_ff @(posedge clk) begin
    if (step && hi_we) begin
      ident_hi <= rx_byte;
    end
    if (step && lo_we) begin
      ident_lo <= rx_byte;
    end
    if (step && data_we) begin
      data_store[data_addr] <= rx_byte;
    end
  end

  assign dlen = frame_length[3:0] - cdf_pkg::HdrLen;

  always_comb begin
    result.can_ident = {1'b0, ident_hi, ident_lo} + 17'd1;
    result.data_len  = dlen;
    for (int k = 0; k < cdf_pkg::NumPay; k++) begin
      result.payload[k] = (4'(k) < dlen) ? data_store[k] : 8'd0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/xor_checked_frame_to_can_deframer_core.sv =====
// Top level: input register, frame parser and result register of the deframer.
//
// Input channel: rx_byte and chunk_end with in_valid / in_stall; one byte per
// transfer. Result channel: can_ident, data_len, payload0..7 with out_valid /
// out_stall; one transfer per frame whose check byte matches.
// A byte goes into the input register on its transfer and is parsed from
// there; the result of a good frame is loaded into the result register when
// its check byte is parsed. One byte per cycle is taken sustained while no
// good frame's check byte waits for the result register.
// A byte that completes no frame is parsed even while a result waits; a byte
// that completes a good frame waits in the input register until the result
// register is free, and in_stall rises meanwhile.
// chunk_end returns the parser to waiting for a length byte after its byte
// is handled; a frame cut off there is dropped.
// Reset (rst, synchronous) empties both registers and sets the parser to
// wait for a length byte. Bad checks and bad lengths give no output.
`default_nettype none
module xor_checked_frame_to_can_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        chunk_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      can_ident,
  output logic [3:0]       data_len,
  output logic [7:0]       payload0,
  output logic [7:0]       payload1,
  output logic [7:0]       payload2,
  output logic [7:0]       payload3,
  output logic [7:0]       payload4,
  output logic [7:0]       payload5,
  output logic [7:0]       payload6,
  output logic [7:0]       payload7
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       hit, advance, out_free, in_xfer;
  cdf_pkg::result_t result;
  cdf_pkg::result_t out_q;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && (!hit || out_free);
  assign in_stall = s1_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  cdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (s1_byte),
    .chunk_end (s1_last),
    .hit       (hit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte <= rx_byte;
      s1_last <= chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_q <= result;
    end
  end

  assign can_ident = out_q.can_ident;
  assign data_len  = out_q.data_len;
  assign payload0  = out_q.payload[0];
  assign payload1  = out_q.payload[1];
  assign payload2  = out_q.payload[2];
  assign payload3  = out_q.payload[3];
  assign payload4  = out_q.payload[4];
  assign payload5  = out_q.payload[5];
  assign payload6  = out_q.payload[6];
  assign payload7  = out_q.payload[7];

  a_hit_loads: assert property (@(posedge clk) disable iff (rst)
    (advance && hit) |=> out_valid)
    else $error("good frame did not reach the result register");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (data_len <= 4'd8 && can_ident != 17'd0))
    else $error("result length or identifier out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_len == 4'd0) |-> (payload0 == 8'd0 && payload7 == 8'd0))
    else $error("unused payload byte not zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(advance && hit))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== tb/sv/tb_xor_checked_frame_to_can_deframer_core.sv =====
// Self-checking testbench for the checked frame to CAN deframer core.
`timescale 1ns / 1ps
module tb_xor_checked_frame_to_can_deframer_core;

  localparam int RandBytes  = 400;
  localparam int CycleLimit = 300000;
  localparam int DrainWait  = 20;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;
  typedef enum int {STALL_NONE, STALL_RAND, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        chunk_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] can_ident;
  logic [3:0]  data_len;
  logic [7:0]  payload0, payload1, payload2, payload3;
  logic [7:0]  payload4, payload5, payload6, payload7;

  xor_checked_frame_to_can_deframer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .chunk_end (chunk_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .can_ident (can_ident),
    .data_len  (data_len),
    .payload0  (payload0),
    .payload1  (payload1),
    .payload2  (payload2),
    .payload3  (payload3),
    .payload4  (payload4),
    .payload5  (payload5),
    .payload6  (payload6),
    .payload7  (payload7)
  );

  stream_byte_t       pending[$];
  cdf_pkg::result_t   exp_frames[$];
  int                 cyc = 0;
  int                 mismatches = 0;
  int                 bytes_sent = 0;
  int                 frames_checked = 0;

  // parser shadow state
  cdf_pkg::phase_t    ph;
  logic [7:0]         flen;
  logic [7:0]         bidx;
  logic [7:0]         rxor;
  logic [15:0]        idb;
  logic [7:0]         dstore [cdf_pkg::NumPay];

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  task automatic clear_shadow();
    ph   = cdf_pkg::PH_WAIT;
    flen = '0;
    bidx = '0;
    rxor = '0;
    idb  = '0;
    for (int k = 0; k < cdf_pkg::NumPay; k++) dstore[k] = '0;
  endtask

  // Advance the shadow parser by one byte; queue a frame when the check matches.
  task automatic track_byte(input logic [7:0] b, input logic last);
    cdf_pkg::result_t r;
    logic [3:0]       dl;
    case (ph)
      cdf_pkg::PH_WAIT: begin
        if (b == 8'h00) begin
          ph = cdf_pkg::PH_HALT;
        end else if (b < cdf_pkg::LenMin || b > cdf_pkg::LenMax) begin
          flen = b;
          bidx = cdf_pkg::IdxHi;
          ph   = (b == cdf_pkg::LenOne) ? cdf_pkg::PH_WAIT : cdf_pkg::PH_SKIP;
        end else begin
          flen = b;
          bidx = cdf_pkg::IdxHi;
          rxor = b;
          idb  = '0;
          for (int k = 0; k < cdf_pkg::NumPay; k++) dstore[k] = '0;
          ph   = cdf_pkg::PH_FRAME;
        end
      end
      cdf_pkg::PH_FRAME: begin
        if (int'(bidx) + 1 >= int'(flen)) begin
          if (b == rxor) begin
            dl = flen[3:0] - cdf_pkg::HdrLen;
            r.can_ident = {1'b0, idb} + 17'd1;
            r.data_len  = dl;
            for (int k = 0; k < cdf_pkg::NumPay; k++)
              r.payload[k] = (k < dl) ? dstore[k] : 8'h00;
            exp_frames.push_back(r);
          end
          ph   = cdf_pkg::PH_WAIT;
          bidx = '0;
          rxor = '0;
        end else begin
          if (bidx == cdf_pkg::IdxHi) idb = {b, 8'h00};
          else if (bidx == cdf_pkg::IdxLo) idb = {idb[15:8], b};
          else dstore[3'(bidx[2:0] - cdf_pkg::DataOfs)] = b;
          rxor = rxor ^ b;
          bidx = bidx + 8'd1;
        end
      end
      cdf_pkg::PH_SKIP: begin
        bidx = bidx + 8'd1;
        if (bidx >= flen) begin
          ph   = cdf_pkg::PH_WAIT;
          bidx = '0;
        end
      end
      default: ;
    endcase
    if (last) clear_shadow();
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    stream_byte_t it;
    it.data = b;
    it.last = last;
    pending.push_back(it);
  endtask

  task automatic push_frame(input int len, input logic [15:0] ident, input fill_t fill,
                            input bit bad_check, input bit end_chunk);
    logic [7:0] x;
    logic [7:0] d;
    x = 8'(len);
    push_byte(8'(len), 1'b0);
    push_byte(ident[15:8], 1'b0);
    push_byte(ident[7:0], 1'b0);
    x = x ^ ident[15:8] ^ ident[7:0];
    for (int i = 0; i < len - 4; i++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hff;
        default:   d = 8'($urandom);
      endcase
      push_byte(d, 1'b0);
      x = x ^ d;
    end
    if (bad_check) x = x ^ 8'($urandom_range(1, 255));
    push_byte(x, end_chunk);
  endtask

  // Length byte plus 'keep' bytes, chunk ends on the last one.
  task automatic push_cut(input int len, input int keep);
    push_byte(8'(len), keep == 0);
    for (int i = 1; i <= keep; i++) push_byte(8'($urandom), i == keep);
  endtask

  task automatic push_skip(input int len);
    push_byte(8'(len), 1'b0);
    for (int i = 1; i < len; i++) push_byte(8'($urandom), 1'b0);
  endtask

  // Zero length halts the parser; only chunk end brings it back.
  task automatic push_halt(input int tail);
    push_byte(8'h00, tail == 0);
    for (int i = 1; i <= tail; i++) push_byte(8'($urandom), i == tail);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Sender: bursts of transfers separated by random idle gaps.
  int           burst_left = 0;
  int           idle_left = 0;
  stream_byte_t next_byte;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_byte(rx_byte, chunk_end);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0 || pending.size() == 0) begin
          if (idle_left > 0) idle_left--;
          in_valid <= 1'b0;
        end else begin
          next_byte = pending.pop_front();
          rx_byte   <= next_byte.data;
          chunk_end <= next_byte.last;
          in_valid  <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle_left  = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
          end
        end
      end
    end
  end

  // Receiver: checks each transfer and stalls in modes picked at random.
  stall_mode_t      stall_mode = STALL_NONE;
  cdf_pkg::result_t got_frame;
  cdf_pkg::result_t want_frame;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_frame.can_ident  = can_ident;
        got_frame.data_len   = data_len;
        got_frame.payload[0] = payload0;
        got_frame.payload[1] = payload1;
        got_frame.payload[2] = payload2;
        got_frame.payload[3] = payload3;
        got_frame.payload[4] = payload4;
        got_frame.payload[5] = payload5;
        got_frame.payload[6] = payload6;
        got_frame.payload[7] = payload7;
        if (exp_frames.size() == 0) begin
          $error("unexpected CAN frame: can_ident 0x%0h data_len %0d", can_ident, data_len);
          mismatches++;
        end else begin
          want_frame = exp_frames.pop_front();
          check_field("can_ident", 32'(want_frame.can_ident), 32'(got_frame.can_ident));
          check_field("data_len", 32'(want_frame.data_len), 32'(got_frame.data_len));
          for (int k = 0; k < cdf_pkg::NumPay; k++)
            check_field($sformatf("payload%0d", k), 32'(want_frame.payload[k]),
                        32'(got_frame.payload[k]));
          frames_checked++;
        end
      end
      if (cyc % 50 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RAND:     out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= ((cyc % 7) < 3);
        default:        out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    int   before_n;
    int   counted;
    int   pick;
    int   len;
    logic [15:0] ident;
    bit   timed_out;

    clear_shadow();
    counted   = 0;
    timed_out = 1'b0;

    // directed: extreme idents and lengths, skips, bad check, halt, cut-off
    push_frame(4, 16'h0000, FILL_ZERO, 1'b0, 1'b0);
    push_frame(12, 16'hffff, FILL_ONES, 1'b0, 1'b1);
    push_byte(8'd1, 1'b0);
    push_skip(3);
    push_frame(5, 16'h1234, FILL_RAND, 1'b1, 1'b0);
    push_halt(2);
    push_cut(6, 2);

    while (counted < RandBytes) begin
      before_n = pending.size();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(4, 12);
        case ($urandom_range(0, 9))
          0:       ident = 16'h0000;
          1:       ident = 16'hffff;
          default: ident = 16'($urandom);
        endcase
        push_frame(len, ident, ($urandom_range(0, 9) == 0) ? FILL_ONES : FILL_RAND,
                   $urandom_range(0, 99) < 15, $urandom_range(0, 4) == 0);
      end else if (pick < 80) begin
        case ($urandom_range(0, 9))
          0, 1, 2: push_skip($urandom_range(1, 3));
          9:       push_skip($urandom_range(0, 7) == 0 ? 255 : $urandom_range(13, 255));
          default: push_skip($urandom_range(13, 20));
        endcase
      end else if (pick < 90) begin
        len = $urandom_range(4, 12);
        push_cut(len, $urandom_range(0, len - 2));
      end else if (pick < 95) begin
        push_halt($urandom_range(0, 5));
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 1; i <= len; i++)
          push_byte(8'($urandom), (i == len) || ($urandom_range(0, 3) == 0));
      end
      counted += pending.size() - before_n;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while ((pending.size() != 0 || in_valid || exp_frames.size() != 0) && !timed_out) begin
      @(posedge clk);
      if (cyc >= CycleLimit) timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("timeout after %0d cycles", cyc);
      $display("FAILURE");
    end else begin
      repeat (DrainWait) @(posedge clk);
      if (exp_frames.size() != 0) begin
        $error("%0d expected CAN frames never arrived", exp_frames.size());
        mismatches++;
      end
      $display("Streamed %0d bytes (good, bad-check, cut-off, skipped and halted frames)",
               bytes_sent);
      $display("under bursty input and varied output stalls; %0d CAN frames checked.",
               frames_checked);
      if (mismatches == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

endmodule
